[src/ffa_pkg.sv]
package ffa_pkg;

    localparam int SIZE_W   = 17;
    localparam int BOFF_W   = 16;
    localparam int STAT_W   = 3;
    localparam int OFF_W    = 16;
    localparam int USED_W   = 17;
    localparam int FCNT_W   = 5;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 40;

    localparam logic [SIZE_W-1:0] RESET_POOL = 17'd1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTALLOC = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO     = 3'd4;

    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_SLOT_NEXT = 4'd2;
    localparam logic [3:0] OP_FIT_RD    = 4'd3;
    localparam logic [3:0] OP_FIT_NEXT  = 4'd4;
    localparam logic [3:0] OP_FIT_HIT   = 4'd5;
    localparam logic [3:0] OP_SH_RD     = 4'd6;
    localparam logic [3:0] OP_SH_WR     = 4'd7;
    localparam logic [3:0] OP_A_COMMIT  = 4'd8;
    localparam logic [3:0] OP_D_RD      = 4'd9;
    localparam logic [3:0] OP_D_NEXT    = 4'd10;
    localparam logic [3:0] OP_D_COMMIT  = 4'd11;
    localparam logic [3:0] OP_RESULT    = 4'd12;

    typedef struct packed {
        logic [3:0]        op;
        logic [STAT_W-1:0] st;
    } t_dp_cmd;

    typedef struct packed {
        logic is_dealloc;
        logic size_zero;
        logic slot_free;
        logic slot_end;
        logic fit_end;
        logic fit_ok;
        logic sh_end;
        logic d_match;
        logic list_full;
        logic out_busy;
    } t_dp_sts;

endpackage

[src/first_fit_allocator.sv]
// An allocate scans the slots serially for a free one, checks the free entries in order
// for the first fit and shifts the free list down over the hit entry; a deallocate scans
// the allocated slots serially for a matching offset.
// Throughput: one transaction at a time; input ready returns as the result is loaded,
// and a stalled result holds it low. Writing the pool size reinitializes the allocator.
// Reset: synchronous, active low; pool becomes 1024 bytes, one free entry, no blocks.
module first_fit_allocator #(
    parameter int FREE_ENTRIES  = 16,
    parameter int ALLOC_ENTRIES = 16,
    parameter int ADDR_BITS     = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [ffa_pkg::SIZE_W-1:0] i_cfg_wr_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ffa_pkg::IN_DW-1:0]  s_axis_tdata,  // alloc_size, block_offset
    input  logic                       s_axis_tuser,  // command
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [ffa_pkg::OUT_DW-1:0] m_axis_tdata,  // offset, used_bytes, free_entries
    output logic [ffa_pkg::STAT_W-1:0] m_axis_tuser   // status
);
    import ffa_pkg::*;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [OFF_W-1:0]  out_offset;
    logic [USED_W-1:0] out_used;
    logic [FCNT_W-1:0] out_fcnt;

    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffa_dp #(
        .FREE_ENTRIES  (FREE_ENTRIES),
        .ALLOC_ENTRIES (ALLOC_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_cmd     (s_axis_tuser),
        .i_req_size    (s_axis_tdata[SIZE_W-1:0]),
        .i_req_boff    (s_axis_tdata[SIZE_W+BOFF_W-1:SIZE_W]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_status  (m_axis_tuser),
        .o_out_offset  (out_offset),
        .o_out_used    (out_used),
        .o_out_fcnt    (out_fcnt)
    );

    assign m_axis_tdata = {{(OUT_DW - OFF_W - USED_W - FCNT_W){1'b0}},
                           out_fcnt, out_used, out_offset};

endmodule

[src/ffa_ctrl.sv]
module ffa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ffa_pkg::t_dp_sts i_sts,
    output ffa_pkg::t_dp_cmd o_cmd
);
    import ffa_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_SLOT = 4'd2;
    localparam logic [3:0] S_FRD  = 4'd3;
    localparam logic [3:0] S_FCMP = 4'd4;
    localparam logic [3:0] S_SCHK = 4'd5;
    localparam logic [3:0] S_SWR  = 4'd6;
    localparam logic [3:0] S_ACOM = 4'd7;
    localparam logic [3:0] S_DRD  = 4'd8;
    localparam logic [3:0] S_DCMP = 4'd9;
    localparam logic [3:0] S_DCOM = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]        r_state, n_state;
    logic [STAT_W-1:0] r_st, n_st;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_st     = r_st;
        o_cmd.op = OP_NOP;
        o_cmd.st = r_st;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.is_dealloc) begin
                    n_state = S_DRD;
                end else if (i_sts.size_zero) begin
                    n_st    = ST_ZERO;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                if (i_sts.slot_end) begin
                    n_st    = ST_FULL;
                    n_state = S_DONE;
                end else if (i_sts.slot_free) begin
                    n_state = S_FRD;
                end else begin
                    o_cmd.op = OP_SLOT_NEXT;
                end
            end
            S_FRD: begin
                if (i_sts.fit_end) begin
                    n_st    = ST_NOFIT;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_FIT_RD;
                    n_state  = S_FCMP;
                end
            end
            S_FCMP: begin
                if (i_sts.fit_ok) begin
                    o_cmd.op = OP_FIT_HIT;
                    n_state  = S_SCHK;
                end else begin
                    o_cmd.op = OP_FIT_NEXT;
                    n_state  = S_FRD;
                end
            end
            S_SCHK: begin
                if (i_sts.sh_end) begin
                    n_state = S_ACOM;
                end else begin
                    o_cmd.op = OP_SH_RD;
                    n_state  = S_SWR;
                end
            end
            S_SWR: begin
                o_cmd.op = OP_SH_WR;
                n_state  = S_SCHK;
            end
            S_ACOM: begin
                o_cmd.op = OP_A_COMMIT;
                n_st     = ST_OK;
                n_state  = S_DONE;
            end
            S_DRD: begin
                if (i_sts.slot_end) begin
                    n_st    = ST_NOTALLOC;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_D_RD;
                    n_state  = S_DCMP;
                end
            end
            S_DCMP: begin
                if (i_sts.d_match) begin
                    if (i_sts.list_full) begin
                        n_st    = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DCOM;
                    end
                end else begin
                    o_cmd.op = OP_D_NEXT;
                    n_state  = S_DRD;
                end
            end
            S_DCOM: begin
                o_cmd.op = OP_D_COMMIT;
                n_st     = ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

endmodule

[src/ffa_dp.sv]
module ffa_dp #(
    parameter int FREE_ENTRIES  = 16,
    parameter int ALLOC_ENTRIES = 16,
    parameter int ADDR_BITS     = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [ffa_pkg::SIZE_W-1:0]   i_cfg_wr_data,
    input  ffa_pkg::t_dp_cmd             i_cmd,
    output ffa_pkg::t_dp_sts             o_sts,
    input  logic                         i_req_cmd,
    input  logic [ffa_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [ffa_pkg::BOFF_W-1:0]   i_req_boff,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ffa_pkg::STAT_W-1:0]   o_out_status,
    output logic [ffa_pkg::OFF_W-1:0]    o_out_offset,
    output logic [ffa_pkg::USED_W-1:0]   o_out_used,
    output logic [ffa_pkg::FCNT_W-1:0]   o_out_fcnt
);
    import ffa_pkg::*;

    localparam int OW   = ADDR_BITS;
    localparam int SW   = ADDR_BITS + 1;
    localparam int CMPW = (SW > SIZE_W) ? SW : SIZE_W;
    localparam int MW   = (OW > BOFF_W) ? OW : BOFF_W;
    localparam int XOW  = (OW > OFF_W) ? OW : OFF_W;
    localparam int UW   = (SW > USED_W) ? SW : USED_W;
    localparam int CNTW = $clog2(FREE_ENTRIES + 1);
    localparam int FIW  = $clog2(FREE_ENTRIES);
    localparam int XCW  = (CNTW > FCNT_W) ? CNTW : FCNT_W;
    localparam int AIW  = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
    localparam int ACW  = $clog2(ALLOC_ENTRIES + 1) + 1;
    localparam logic [CMPW-1:0] POOL_MAX = CMPW'(1) << ADDR_BITS;

    function automatic logic [SW-1:0] clamp_pool(input logic [SIZE_W-1:0] v);
        logic [CMPW-1:0] w;
        w = CMPW'(v);
        if (w == '0) begin
            w = CMPW'(1);
        end
        if (w > POOL_MAX) begin
            w = POOL_MAX;
        end
        return w[SW-1:0];
    endfunction

    logic [OW-1:0] r_free_off  [FREE_ENTRIES];
    logic [SW-1:0] r_free_size [FREE_ENTRIES];
    logic [OW-1:0] r_alloc_off  [ALLOC_ENTRIES];
    logic [SW-1:0] r_alloc_size [ALLOC_ENTRIES];

    logic [ALLOC_ENTRIES-1:0] r_valid;
    logic [CNTW-1:0]          r_count;
    logic [SW-1:0]            r_used;
    logic                     r_is_dealloc;
    logic [SIZE_W-1:0]        r_size;
    logic [BOFF_W-1:0]        r_boff;
    logic [ACW-1:0]           r_aidx;
    logic [CNTW-1:0]          r_fidx;
    logic [OW-1:0]            r_frd_off;
    logic [SW-1:0]            r_frd_size;
    logic [OW-1:0]            r_ard_off;
    logic [SW-1:0]            r_ard_size;
    logic [OW-1:0]            r_base;
    logic [SW-1:0]            r_rest;
    logic                     r_out_valid;
    logic [STAT_W-1:0]        r_out_status;
    logic [OFF_W-1:0]         r_out_offset;
    logic [USED_W-1:0]        r_out_used;
    logic [FCNT_W-1:0]        r_out_fcnt;

    logic            init;
    logic [SW-1:0]   init_pool;
    logic [CNTW-1:0] fidx_inc;
    logic [CNTW-1:0] count_dec;
    logic [AIW-1:0]  aaddr;
    logic            fw_en;
    logic [FIW-1:0]  fw_addr;
    logic [OW-1:0]   fw_off;
    logic [SW-1:0]   fw_size;
    logic [FIW-1:0]  fr_addr;
    logic [UW-1:0]   used_x;
    logic [XCW-1:0]  cnt_x;
    logic [XOW-1:0]  base_x;

    assign init      = !i_rst_n || i_cfg_wr_en;
    assign init_pool = clamp_pool(i_rst_n ? i_cfg_wr_data : RESET_POOL);
    assign fidx_inc  = r_fidx + CNTW'(1);
    assign count_dec = r_count - CNTW'(1);
    assign aaddr     = r_aidx[AIW-1:0];
    assign fr_addr   = (i_cmd.op == OP_SH_RD) ? fidx_inc[FIW-1:0] : r_fidx[FIW-1:0];

    always_comb begin
        fw_en   = 1'b0;
        fw_addr = '0;
        fw_off  = r_frd_off;
        fw_size = r_frd_size;
        if (init) begin
            fw_en   = 1'b1;
            fw_off  = '0;
            fw_size = init_pool;
        end else begin
            case (i_cmd.op)
                OP_SH_WR: begin
                    fw_en   = 1'b1;
                    fw_addr = r_fidx[FIW-1:0];
                end
                OP_A_COMMIT: begin
                    fw_en   = (r_rest != '0);
                    fw_addr = count_dec[FIW-1:0];
                    fw_off  = r_base + OW'(r_size);
                    fw_size = r_rest;
                end
                OP_D_COMMIT: begin
                    fw_en   = 1'b1;
                    fw_addr = r_count[FIW-1:0];
                    fw_off  = r_ard_off;
                    fw_size = r_ard_size;
                end
                default: begin
                    fw_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (fw_en) begin
            r_free_off[fw_addr]  <= fw_off;
            r_free_size[fw_addr] <= fw_size;
        end
        if (i_cmd.op == OP_FIT_RD || i_cmd.op == OP_SH_RD) begin
            r_frd_off  <= r_free_off[fr_addr];
            r_frd_size <= r_free_size[fr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!init && i_cmd.op == OP_A_COMMIT) begin
            r_alloc_off[aaddr]  <= r_base;
            r_alloc_size[aaddr] <= SW'(r_size);
        end
        if (i_cmd.op == OP_D_RD) begin
            r_ard_off  <= r_alloc_off[aaddr];
            r_ard_size <= r_alloc_size[aaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_is_dealloc <= i_req_cmd;
                r_size       <= i_req_size;
                r_boff       <= i_req_boff;
                r_aidx       <= '0;
                r_fidx       <= '0;
            end
            OP_SLOT_NEXT, OP_D_NEXT: begin
                r_aidx <= r_aidx + ACW'(1);
            end
            OP_FIT_NEXT, OP_SH_WR: begin
                r_fidx <= fidx_inc;
            end
            OP_FIT_HIT: begin
                r_base <= r_frd_off;
                r_rest <= r_frd_size - SW'(r_size);
            end
            default: begin
            end
        endcase
    end

    assign used_x = UW'(r_used);
    assign cnt_x  = XCW'(r_count);
    assign base_x = XOW'(r_base);

    always_ff @(posedge i_clk) begin
        if (init) begin
            r_valid <= '0;
            r_count <= CNTW'(1);
            r_used  <= '0;
        end else begin
            case (i_cmd.op)
                OP_A_COMMIT: begin
                    r_valid[aaddr] <= 1'b1;
                    r_used         <= r_used + SW'(r_size);
                    if (r_rest == '0) begin
                        r_count <= count_dec;
                    end
                end
                OP_D_COMMIT: begin
                    r_valid[aaddr] <= 1'b0;
                    r_used         <= r_used - r_ard_size;
                    r_count        <= r_count + CNTW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_RESULT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.op == OP_RESULT) begin
            r_out_status <= i_cmd.st;
            r_out_offset <= (i_cmd.st == ST_OK && !r_is_dealloc) ? base_x[OFF_W-1:0] : '0;
            r_out_used   <= used_x[USED_W-1:0];
            r_out_fcnt   <= cnt_x[FCNT_W-1:0];
        end
    end

    always_comb begin
        o_sts.is_dealloc = r_is_dealloc;
        o_sts.size_zero  = (r_size == '0);
        o_sts.slot_end   = (r_aidx >= ACW'(ALLOC_ENTRIES));
        o_sts.slot_free  = !r_valid[aaddr];
        o_sts.fit_end    = (r_fidx >= r_count);
        o_sts.fit_ok     = (CMPW'(r_frd_size) >= CMPW'(r_size));
        o_sts.sh_end     = (fidx_inc >= r_count);
        o_sts.d_match    = r_valid[aaddr] && (MW'(r_ard_off) == MW'(r_boff));
        o_sts.list_full  = (r_count >= CNTW'(FREE_ENTRIES));
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_offset = r_out_offset;
    assign o_out_used   = r_out_used;
    assign o_out_fcnt   = r_out_fcnt;

endmodule

[tb/ffa_checker.sv]
`timescale 1ns / 1ps

module ffa_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [ffa_pkg::SIZE_W-1:0] i_cfg_wr_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [ffa_pkg::IN_DW-1:0]  i_in_data,
    input  logic                       i_in_cmd,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [ffa_pkg::OUT_DW-1:0] i_out_data,
    input  logic [ffa_pkg::STAT_W-1:0] i_out_status,
    output int                         o_errors,
    output int                         o_pending
);
    import ffa_pkg::*;

    localparam int NF = 16;
    localparam int NA = 16;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  offset;
        logic [USED_W-1:0] used;
        logic [FCNT_W-1:0] fcnt;
    } t_reply;

    t_reply             replies_due[$];
    logic [15:0]        fl_off [NF];
    logic [16:0]        fl_size[NF];
    int                 fl_cnt;
    logic [15:0]        blk_off [NA];
    logic [16:0]        blk_size[NA];
    logic               blk_live[NA];
    logic [16:0]        used_sum;

    function automatic void reinit(input logic [16:0] v);
        logic [16:0] p;
        p = (v == 0) ? 17'd1 : (v > 17'd65536 ? 17'd65536 : v);
        for (int i = 0; i < NA; i++) blk_live[i] = 1'b0;
        fl_off[0] = '0;
        fl_size[0] = p;
        fl_cnt = 1;
        used_sum = '0;
    endfunction

    function automatic t_reply serve(input logic cmd, input logic [16:0] sz,
                                     input logic [15:0] boff);
        t_reply r;
        int slot, hit;
        logic [15:0] base;
        logic [16:0] rest;
        r = '0;
        slot = NA;
        hit = NF;
        if (cmd == CMD_ALLOC) begin
            if (sz == 0) begin
                r.status = ST_ZERO;
            end else begin
                for (int i = NA - 1; i >= 0; i--) if (!blk_live[i]) slot = i;
                for (int i = fl_cnt - 1; i >= 0; i--) if (fl_size[i] >= sz) hit = i;
                if (slot == NA) begin
                    r.status = ST_FULL;
                end else if (hit == NF) begin
                    r.status = ST_NOFIT;
                end else begin
                    base = fl_off[hit];
                    rest = fl_size[hit] - sz;
                    for (int i = hit; i + 1 < fl_cnt; i++) begin
                        fl_off[i] = fl_off[i+1];
                        fl_size[i] = fl_size[i+1];
                    end
                    fl_cnt--;
                    if (rest > 0) begin
                        fl_off[fl_cnt] = base + sz[15:0];
                        fl_size[fl_cnt] = rest;
                        fl_cnt++;
                    end
                    blk_off[slot] = base;
                    blk_size[slot] = sz;
                    blk_live[slot] = 1'b1;
                    used_sum += sz;
                    r.status = ST_OK;
                    r.offset = base;
                end
            end
        end else begin
            for (int i = NA - 1; i >= 0; i--)
                if (blk_live[i] && blk_off[i] == boff) slot = i;
            if (slot == NA) begin
                r.status = ST_NOTALLOC;
            end else if (fl_cnt >= NF) begin
                r.status = ST_FULL;
            end else begin
                blk_live[slot] = 1'b0;
                used_sum -= blk_size[slot];
                fl_off[fl_cnt] = boff;
                fl_size[fl_cnt] = blk_size[slot];
                fl_cnt++;
                r.status = ST_OK;
            end
        end
        r.used = used_sum;
        r.fcnt = fl_cnt[4:0];
        return r;
    endfunction

    assign o_pending = replies_due.size();

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            reinit(RESET_POOL);
            replies_due.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_wr_en) reinit(i_cfg_wr_data);
            if (i_in_valid && i_in_ready)
                replies_due.push_back(serve(i_in_cmd, i_in_data[16:0], i_in_data[32:17]));
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    want = replies_due.pop_front();
                    if (i_out_status !== want.status ||
                        i_out_data[15:0] !== want.offset ||
                        i_out_data[32:16] !== want.used ||
                        i_out_data[37:33] !== want.fcnt) begin
                        if (i_out_status !== want.status)
                            $error("status exp %0d got %0d", want.status, i_out_status);
                        if (i_out_data[15:0] !== want.offset)
                            $error("offset exp %0d got %0d", want.offset, i_out_data[15:0]);
                        if (i_out_data[32:16] !== want.used)
                            $error("used_bytes exp %0d got %0d", want.used,
                                   i_out_data[32:16]);
                        if (i_out_data[37:33] !== want.fcnt)
                            $error("free_entries exp %0d got %0d", want.fcnt,
                                   i_out_data[37:33]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ffa_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_wr_en;
    logic [SIZE_W-1:0]  cfg_wr_data;
    logic               req_valid;
    logic               req_ready;
    logic [IN_DW-1:0]   req_data;
    logic               req_cmd;
    logic               rsp_valid;
    logic               rsp_ready;
    logic [OUT_DW-1:0]  rsp_data;
    logic [STAT_W-1:0]  rsp_status;
    int                 errors;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    logic [15:0]        live_offs[$];

    first_fit_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (req_valid),
        .s_axis_tready (req_ready),
        .s_axis_tdata  (req_data),
        .s_axis_tuser  (req_cmd),
        .m_axis_tvalid (rsp_valid),
        .m_axis_tready (rsp_ready),
        .m_axis_tdata  (rsp_data),
        .m_axis_tuser  (rsp_status)
    );

    ffa_checker i_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (req_valid),
        .i_in_ready    (req_ready),
        .i_in_data     (req_data),
        .i_in_cmd      (req_cmd),
        .i_out_valid   (rsp_valid),
        .i_out_ready   (rsp_ready),
        .i_out_data    (rsp_data),
        .i_out_status  (rsp_status),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("** first_fit_allocator: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_valid && rsp_ready && rsp_status == ST_OK) begin
            live_offs.push_back(rsp_data[OFF_W-1:0]);
        end
    end

    task automatic send(input logic cmd, input logic [16:0] sz, input logic [15:0] boff);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        req_valid <= 1'b1;
        req_cmd <= cmd;
        req_data <= {7'd0, boff, sz};
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        req_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_pool(input logic [16:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item(input int pool);
        int pick;
        logic [16:0] sz;
        logic [15:0] boff;
        pick = $urandom_range(99);
        if (pick < 50) begin
            sz = (pick < 3) ? 17'($urandom_range(131071)) :
                 17'($urandom_range(1, pool / 4 + 1));
            send(CMD_ALLOC, sz, 16'($urandom));
        end else if (pick < 90) begin
            if (live_offs.size() != 0 && $urandom_range(1) == 0)
                boff = live_offs[$urandom_range(live_offs.size() - 1)];
            else
                boff = 16'($urandom_range(pool - 1));
            send(CMD_FREE, 17'($urandom), boff);
        end else begin
            send(1'($urandom), 17'($urandom), 16'($urandom));
        end
    endtask

    task automatic run_phase(input int n, input int idle, input int stall, input int pool);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) random_item(pool);
    endtask

    initial begin
        int pools[6];
        i_rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req_valid = 1'b0;
        req_data = '0;
        req_cmd = CMD_ALLOC;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset pool of 1024
        send(CMD_ALLOC, 17'd0, 16'd0);
        send(CMD_ALLOC, 17'd131071, 16'hFFFF);
        send(CMD_ALLOC, 17'd1025, 16'd0);
        send(CMD_ALLOC, 17'd100, 16'd0);
        send(CMD_ALLOC, 17'd924, 16'd0);
        send(CMD_ALLOC, 17'd1, 16'd0);
        send(CMD_FREE, 17'd0, 16'd5);
        send(CMD_FREE, 17'd0, 16'd0);
        send(CMD_FREE, 17'd0, 16'd0);
        send(CMD_FREE, 17'd0, 16'd100);
        send(CMD_ALLOC, 17'd50, 16'd0);
        write_pool(17'd64);
        for (int i = 0; i < 17; i++) send(CMD_ALLOC, 17'd1, 16'd0);
        for (int i = 0; i < 16; i++) send(CMD_FREE, 17'd0, 16'(i));
        write_pool(17'd0);
        send(CMD_ALLOC, 17'd1, 16'd0);
        send(CMD_ALLOC, 17'd1, 16'd0);
        write_pool(17'h1FFFF);
        send(CMD_ALLOC, 17'd65536, 16'd0);
        send(CMD_FREE, 17'd0, 16'd0);
        write_pool(17'd65536);
        send(CMD_ALLOC, 17'd65535, 16'd0);
        send(CMD_FREE, 17'h1FFFF, 16'hFFFF);

        pools = '{256, 64, 65536, 1024, 16, 4096};
        for (int ph = 0; ph < 6; ph++) begin
            write_pool(17'(pools[ph]));
            case (ph % 4)
                0: run_phase(62, 0, 0, pools[ph]);
                1: run_phase(62, 83, 0, pools[ph]);
                2: run_phase(62, 0, 83, pools[ph]);
                default: run_phase(62, 8, 8, pools[ph]);
            endcase
            drain();
            for (int k = 0; k < 4; k++) begin
                case (k)
                    0: run_phase(62, 0, 0, pools[ph]);
                    1: run_phase(62, 83, 0, pools[ph]);
                    2: run_phase(62, 0, 83, pools[ph]);
                    default: run_phase(62, 8, 8, pools[ph]);
                endcase
            end
        end

        drain();
        if (errors == 0) begin
            $display("** first_fit_allocator: PASSED **");
        end else begin
            $display("** first_fit_allocator: FAILED **");
        end
        $finish;
    end
endmodule
